FILE: rtl/pspsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pspsq_pkg: shared types and constants of the pressure sensor poll sequencer
// Event codes, bus request codes, sequencer phases and field widths.
// ----------------------------------------------------------------------------
package pspsq_pkg;

    localparam int ACTION_W = 2;
    localparam int DATA_W   = 24;
    localparam int RANGE_W  = 10;
    localparam int SCALE_W  = 27;
    localparam int PRESS_W  = 28;
    localparam int TEMP_W   = 16;
    localparam int CNT_W    = 3;

    localparam logic [CNT_W-1:0] POLL_ATTEMPTS = CNT_W'(6);
    localparam logic [CNT_W-1:0] FAIL_AFTER    = CNT_W'(5);

    localparam logic [ACTION_W-1:0] ACT_TICK       = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELAY_DONE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BUS_DONE   = 2'd2;

    // status byte: sensor busy while this bit is set
    localparam int STATUS_BUSY_BIT = 3;

    localparam int PA_PER_BAR_INT  = 100000;
    localparam int RANGE_RESET_INT = 10;
    localparam logic [SCALE_W-1:0] PA_PER_BAR  = SCALE_W'(PA_PER_BAR_INT);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(RANGE_RESET_INT * PA_PER_BAR_INT);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_DELAY,
        PH_STATUS,
        PH_PRESS,
        PH_TEMP
    } phase_t;

    typedef enum logic [2:0] {
        REQ_NONE,
        REQ_CMD,
        REQ_STATUS,
        REQ_PRESS,
        REQ_TEMP
    } req_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                bus_error;
        logic [DATA_W-1:0]   bus_data;
    } item_t;

    typedef struct packed {
        req_t               bus_request;
        logic               start_delay;
        logic               publish;
        logic [PRESS_W-1:0] pressure_pa;
        logic [TEMP_W-1:0]  temperature_q8;
        logic               warning;
        logic               failed;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/pspsq_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pspsq_scale: raw pressure to pascals
// Holds range_bar * 100000 as the scale factor and multiplies the signed
// 24-bit raw reading by it; the result is the product shifted right by 23
// with floor rounding.
// ----------------------------------------------------------------------------
module pspsq_scale (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [pspsq_pkg::RANGE_W-1:0] cfg_wr_data,
    input  wire logic [pspsq_pkg::DATA_W-1:0]  raw,
    output logic      [pspsq_pkg::PRESS_W-1:0] pressure
);
    import pspsq_pkg::*;

    localparam int PROD_W = DATA_W + SCALE_W + 1;

    logic [SCALE_W-1:0]       scale_reg;
    logic [SCALE_W-1:0]       scale_next;
    logic signed [PROD_W-1:0] product;

    // constant multiply, fits: 1023 * 100000 < 2**27
    assign scale_next = {{(SCALE_W - RANGE_W){1'b0}}, cfg_wr_data} * PA_PER_BAR;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            scale_reg <= scale_next;
        end
    end

    assign product  = $signed(raw) * $signed({1'b0, scale_reg});
    // arithmetic shift by 23 is floor division by 2**23
    assign pressure = product[PRESS_W+22:23];

endmodule
`default_nettype wire

FILE: rtl/pspsq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pspsq_ctrl: measurement sequencer
// Walks command write, status polls, pressure read and temperature read;
// tracks poll attempts, consecutive failures, warning and failed flags.
// ----------------------------------------------------------------------------
module pspsq_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire pspsq_pkg::item_t              item,
    input  wire logic [pspsq_pkg::PRESS_W-1:0] pressure_scaled,
    output pspsq_pkg::result_t                 result
);
    import pspsq_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [CNT_W-1:0]   poll_count_reg;
    logic [CNT_W-1:0]   poll_count_next;
    logic [CNT_W-1:0]   error_count_reg;
    logic [CNT_W-1:0]   error_count_next;
    logic               warning_reg;
    logic               warning_next;
    logic               failed_reg;
    logic               failed_next;
    logic [PRESS_W-1:0] pressure_hold_reg;
    logic [PRESS_W-1:0] pressure_hold_next;

    logic busy;
    logic polls_used;
    logic bus_done;
    logic comm_fail;
    req_t req;
    logic delay;
    logic pub;

    assign busy       = item.bus_data[STATUS_BUSY_BIT];
    assign polls_used = (poll_count_reg >= POLL_ATTEMPTS);
    assign bus_done   = !failed_reg && (item.action == ACT_BUS_DONE);

    always_comb
    begin
        comm_fail = 1'b0;
        if (bus_done)
        begin
            case (phase_reg)
                PH_CMD, PH_PRESS, PH_TEMP: comm_fail = item.bus_error;
                PH_STATUS: comm_fail = item.bus_error || (busy && polls_used);
                default: comm_fail = 1'b0;
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        poll_count_next    = poll_count_reg;
        error_count_next   = error_count_reg;
        warning_next       = warning_reg;
        failed_next        = failed_reg;
        pressure_hold_next = pressure_hold_reg;
        if (comm_fail)
        begin
            warning_next = 1'b1;
            phase_next   = PH_IDLE;
            if (error_count_reg >= FAIL_AFTER)
            begin
                failed_next = 1'b1;
            end
            else
            begin
                error_count_next = error_count_reg + CNT_W'(1);
            end
        end
        else if (!failed_reg)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                ACT_DELAY_DONE:
                begin
                    if (phase_reg == PH_DELAY)
                    begin
                        phase_next = PH_STATUS;
                    end
                end
                ACT_BUS_DONE:
                begin
                    case (phase_reg)
                        PH_CMD:
                        begin
                            poll_count_next = CNT_W'(1);
                            phase_next      = PH_DELAY;
                        end
                        PH_STATUS:
                        begin
                            if (!busy)
                            begin
                                phase_next = PH_PRESS;
                            end
                            else
                            begin
                                poll_count_next = poll_count_reg + CNT_W'(1);
                                phase_next      = PH_DELAY;
                            end
                        end
                        PH_PRESS:
                        begin
                            pressure_hold_next = pressure_scaled;
                            phase_next         = PH_TEMP;
                        end
                        PH_TEMP:
                        begin
                            error_count_next = '0;
                            warning_next     = 1'b0;
                            phase_next       = PH_IDLE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        req   = REQ_NONE;
        delay = 1'b0;
        pub   = 1'b0;
        if (!failed_reg && !comm_fail)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        req = REQ_CMD;
                    end
                end
                ACT_DELAY_DONE:
                begin
                    if (phase_reg == PH_DELAY)
                    begin
                        req = REQ_STATUS;
                    end
                end
                ACT_BUS_DONE:
                begin
                    case (phase_reg)
                        PH_CMD:    delay = 1'b1;
                        PH_STATUS:
                        begin
                            if (!busy)
                            begin
                                req = REQ_PRESS;
                            end
                            else
                            begin
                                delay = 1'b1;
                            end
                        end
                        PH_PRESS:  req = REQ_TEMP;
                        PH_TEMP:   pub = 1'b1;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result.bus_request    = req;
        result.start_delay    = delay;
        result.publish        = pub;
        result.pressure_pa    = pub ? pressure_hold_reg : '0;
        result.temperature_q8 = pub ? item.bus_data[TEMP_W-1:0] : '0;
        result.warning        = warning_next;
        result.failed         = failed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            poll_count_reg    <= '0;
            error_count_reg   <= '0;
            warning_reg       <= 1'b0;
            failed_reg        <= 1'b0;
            pressure_hold_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            poll_count_reg    <= poll_count_next;
            error_count_reg   <= error_count_next;
            warning_reg       <= warning_next;
            failed_reg        <= failed_next;
            pressure_hold_reg <= pressure_hold_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pressure_sensor_poll_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_sensor_poll_sequencer: one measurement of an I2C pressure sensor
// Input channel (in_valid/in_stall) carries events: update tick, poll delay
// elapsed, or bus transfer finished with error flag and read data. Each
// event transfer yields exactly one result transfer on the output channel
// (out_valid/out_stall): bus request, delay start, publish with pressure in
// pascals and Q8.8 temperature, plus the warning and failed flags.
// The path has two registers: an input register, then the sequencer and pressure
// multiply (24 x 28 bits) into the result register. One event is taken every
// cycle while results drain. While the output is stalled the result holds,
// one more event waits in the input register, and then in_stall rises.
// range_bar is written through cfg_wr_en/cfg_wr_data between measurements.
// Reset clears the sequencer to idle, clears the counters and flags, sets
// range_bar to 10 bar and empties both registers.
// ----------------------------------------------------------------------------
module pressure_sensor_poll_sequencer (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_wr_en,
    input  wire logic        [pspsq_pkg::RANGE_W-1:0]  cfg_wr_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic        [pspsq_pkg::ACTION_W-1:0] action,
    input  wire logic                                 bus_error,
    input  wire logic        [pspsq_pkg::DATA_W-1:0]   bus_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic             [2:0]                    bus_request,
    output logic                                      start_delay,
    output logic                                      publish,
    output logic signed      [pspsq_pkg::PRESS_W-1:0]  pressure_pa,
    output logic signed      [pspsq_pkg::TEMP_W-1:0]   temperature_q8,
    output logic                                      warning,
    output logic                                      failed
);
    import pspsq_pkg::*;

    logic               s1_valid_reg;
    item_t              s1_item_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               out_free;
    logic               step;
    logic [PRESS_W-1:0] pressure_scaled;
    result_t            result;

    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    pspsq_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .raw         (s1_item_reg.bus_data),
        .pressure    (pressure_scaled)
    );

    pspsq_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .item            (s1_item_reg),
        .pressure_scaled (pressure_scaled),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_item_reg.action    <= action;
            s1_item_reg.bus_error <= bus_error;
            s1_item_reg.bus_data  <= bus_data;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign bus_request    = out_reg.bus_request;
    assign start_delay    = out_reg.start_delay;
    assign publish        = out_reg.publish;
    assign pressure_pa    = out_reg.pressure_pa;
    assign temperature_q8 = out_reg.temperature_q8;
    assign warning        = out_reg.warning;
    assign failed         = out_reg.failed;

endmodule
`default_nettype wire

FILE: tb/tb_pressure_sensor_poll_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pressure_sensor_poll_sequencer: self-checking bench for the poll sequencer
// A scripted opening walks the measurement chain, its error exits and the
// ignored events. Random measurements with random content and some noise
// follow under several pressure ranges, each reached at a drain point. The
// run closes with forced bus errors until the sequencer latches failed.
// Every result is compared field by field with the scripted value or with
// a predictor that runs at each input transfer. The sender works in bursts
// and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_poll_sequencer;
    import pspsq_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int SEGMENT_EVENTS = 250;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        phase_t             ph;
        logic [CNT_W-1:0]   polls;
        logic [CNT_W-1:0]   errs;
        logic               warn;
        logic               fail;
        logic [PRESS_W-1:0] hold;
    } seq_state_t;

    typedef struct packed {
        item_t   ev;
        logic    known;
        result_t want;
    } script_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_wr_en = 1'b0;
    logic [RANGE_W-1:0]          cfg_wr_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [ACTION_W-1:0]         action = '0;
    logic                        bus_error = 1'b0;
    logic [DATA_W-1:0]           bus_data = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [2:0]                  bus_request;
    logic                        start_delay;
    logic                        publish;
    logic signed [PRESS_W-1:0]   pressure_pa;
    logic signed [TEMP_W-1:0]    temperature_q8;
    logic                        warning;
    logic                        failed;

    seq_state_t         st = '0;
    logic [RANGE_W-1:0] range_setting = RANGE_W'(RANGE_RESET_INT);
    result_t            pending_results[$];
    script_row_t        script[27];

    int cycles = 0;
    int mismatches = 0;
    int results_seen = 0;
    int events_sent = 0;
    int measurements_published = 0;
    int comm_failures = 0;
    int range_writes = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;

    pressure_sensor_poll_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .bus_error      (bus_error),
        .bus_data       (bus_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .bus_request    (bus_request),
        .start_delay    (start_delay),
        .publish        (publish),
        .pressure_pa    (pressure_pa),
        .temperature_q8 (temperature_q8),
        .warning        (warning),
        .failed         (failed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t ev_of(input logic [ACTION_W-1:0] a, input logic e,
                                    input logic [DATA_W-1:0] d);
        item_t ev;
        ev.action    = a;
        ev.bus_error = e;
        ev.bus_data  = d;
        return ev;
    endfunction

    function automatic result_t res_of(input req_t req, input logic dly, input logic pub,
                                       input logic [PRESS_W-1:0] p, input logic [TEMP_W-1:0] t,
                                       input logic w, input logic f);
        result_t r;
        r.bus_request    = req;
        r.start_delay    = dly;
        r.publish        = pub;
        r.pressure_pa    = p;
        r.temperature_q8 = t;
        r.warning        = w;
        r.failed         = f;
        return r;
    endfunction

    // floor(sext(raw) * range * 100000 / 2^23), kept to the output width
    function automatic logic [PRESS_W-1:0] to_pascal(input logic [DATA_W-1:0] raw);
        longint prod;
        prod = longint'($signed(raw)) * longint'(range_setting) * longint'(PA_PER_BAR_INT);
        return PRESS_W'(prod >>> 23);
    endfunction

    function automatic void mark_comm_failure(inout seq_state_t s);
        s.warn = 1'b1;
        if (s.errs >= FAIL_AFTER)
            s.fail = 1'b1;
        else
            s.errs = s.errs + 1'b1;
        s.ph = PH_IDLE;
    endfunction

    function automatic result_t advance_sequencer(inout seq_state_t s, input item_t ev);
        result_t r;
        r = '0;
        if (!s.fail)
        begin
            case (ev.action)
                ACT_TICK:
                    if (s.ph == PH_IDLE)
                    begin
                        r.bus_request = REQ_CMD;
                        s.ph = PH_CMD;
                    end
                ACT_DELAY_DONE:
                    if (s.ph == PH_DELAY)
                    begin
                        r.bus_request = REQ_STATUS;
                        s.ph = PH_STATUS;
                    end
                ACT_BUS_DONE:
                    case (s.ph)
                        PH_CMD:
                            if (ev.bus_error)
                                mark_comm_failure(s);
                            else
                            begin
                                s.polls = CNT_W'(1);
                                r.start_delay = 1'b1;
                                s.ph = PH_DELAY;
                            end
                        PH_STATUS:
                            if (ev.bus_error)
                                mark_comm_failure(s);
                            else if (!ev.bus_data[STATUS_BUSY_BIT])
                            begin
                                r.bus_request = REQ_PRESS;
                                s.ph = PH_PRESS;
                            end
                            else if (s.polls >= POLL_ATTEMPTS)
                                mark_comm_failure(s);
                            else
                            begin
                                s.polls = s.polls + 1'b1;
                                r.start_delay = 1'b1;
                                s.ph = PH_DELAY;
                            end
                        PH_PRESS:
                            if (ev.bus_error)
                                mark_comm_failure(s);
                            else
                            begin
                                s.hold = to_pascal(ev.bus_data);
                                r.bus_request = REQ_TEMP;
                                s.ph = PH_TEMP;
                            end
                        PH_TEMP:
                            if (ev.bus_error)
                                mark_comm_failure(s);
                            else
                            begin
                                r.publish = 1'b1;
                                r.pressure_pa = s.hold;
                                r.temperature_q8 = ev.bus_data[TEMP_W-1:0];
                                s.errs = '0;
                                s.warn = 1'b0;
                                s.ph = PH_IDLE;
                            end
                        default: ;
                    endcase
                default: ;
            endcase
        end
        r.warning = s.warn;
        r.failed  = s.fail;
        return r;
    endfunction

    // Mostly the event the sequencer waits for, with random content; the rest
    // is noise. Unless latching is allowed, drop any event that would latch.
    function automatic item_t pick_event(input int err_pct, input bit allow_latch);
        item_t      ev;
        seq_state_t trial;
        result_t    r;
        do
        begin
            ev.bus_data  = DATA_W'($urandom);
            ev.bus_error = ($urandom_range(0, 99) < err_pct);
            if ($urandom_range(0, 99) < 85)
            begin
                case (st.ph)
                    PH_IDLE:  ev.action = ACT_TICK;
                    PH_DELAY: ev.action = ACT_DELAY_DONE;
                    default:  ev.action = ACT_BUS_DONE;
                endcase
                if (st.ph == PH_STATUS)
                    ev.bus_data[STATUS_BUSY_BIT] = ($urandom_range(0, 9) < 6);
                if (st.ph == PH_PRESS && $urandom_range(0, 7) == 0)
                    case ($urandom_range(0, 3))
                        0: ev.bus_data = 24'h800000;
                        1: ev.bus_data = 24'h7FFFFF;
                        2: ev.bus_data = 24'hFFFFFF;
                        default: ev.bus_data = 24'h000000;
                    endcase
            end
            else
            begin
                ev.action    = ACTION_W'($urandom_range(0, 3));
                ev.bus_error = 1'($urandom);
            end
            trial = st;
            r = advance_sequencer(trial, ev);
        end while (!allow_latch && trial.fail && !st.fail);
        return ev;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got 0x%0h, want 0x%0h (result %0d, cycle %0d)",
                 field, got, want, results_seen, cycles);
        mismatches++;
    endtask

    task automatic check_result(input result_t want);
        if (bus_request !== want.bus_request)
            report("bus_request", 32'(bus_request), 32'(want.bus_request));
        if (start_delay !== want.start_delay)
            report("start_delay", 32'(start_delay), 32'(want.start_delay));
        if (publish !== want.publish)
            report("publish", 32'(publish), 32'(want.publish));
        if (pressure_pa !== want.pressure_pa)
            report("pressure_pa", 32'(pressure_pa), 32'(want.pressure_pa));
        if (temperature_q8 !== want.temperature_q8)
            report("temperature_q8", 32'(temperature_q8), 32'(want.temperature_q8));
        if (warning !== want.warning)
            report("warning", 32'(warning), 32'(want.warning));
        if (failed !== want.failed)
            report("failed", 32'(failed), 32'(want.failed));
    endtask

    // Drive one event, hold it until the transfer, then record its outcome.
    task automatic send(input item_t ev, input logic known, input result_t want);
        seq_state_t prev;
        result_t    r;
        action    <= ev.action;
        bus_error <= ev.bus_error;
        bus_data  <= ev.bus_data;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        prev = st;
        r = advance_sequencer(st, ev);
        pending_results.push_back(known ? want : r);
        events_sent++;
        if (r.publish)
            measurements_published++;
        if (st.warn && (st.errs != prev.errs || st.fail != prev.fail))
            comm_failures++;
    endtask

    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_range(input logic [RANGE_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        range_setting = value;
        range_writes++;
    endtask

    // receiver: switch between stall patterns every so often
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        else
            stall_left = stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((cycles % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report("unexpected result, bus_request", 32'(bus_request), 32'(REQ_NONE));
            else
                check_result(pending_results.pop_front());
        end
    end

    initial
    begin
        logic [RANGE_W-1:0] seg_range[6];
        seg_range = '{RANGE_W'(1000), RANGE_W'(1), RANGE_W'(0), RANGE_W'(1023),
                      RANGE_W'($urandom_range(1, 1000)), RANGE_W'(500)};
        script = '{
            '{ev_of(ACT_UNUSED,     1'b1, 24'hFFFFFF), 1'b1,
              res_of(REQ_NONE,   1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_BUS_DONE,   1'b1, 24'hFFFFFF), 1'b1,
              res_of(REQ_NONE,   1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_DELAY_DONE, 1'b0, 24'h000000), 1'b1,
              res_of(REQ_NONE,   1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_TICK,       1'b0, 24'h000000), 1'b1,
              res_of(REQ_CMD,    1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            // a tick in the middle of a measurement is dropped
            '{ev_of(ACT_TICK,       1'b1, 24'hFFFFFF), 1'b1,
              res_of(REQ_NONE,   1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h000000), 1'b1,
              res_of(REQ_NONE,   1'b1, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_DELAY_DONE, 1'b0, 24'h000000), 1'b1,
              res_of(REQ_STATUS, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h000008), 1'b1,
              res_of(REQ_NONE,   1'b1, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_DELAY_DONE, 1'b0, 24'hFFFFFF), 1'b0, '0},
            // ready: only the busy bit matters
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'hFFFFF7), 1'b1,
              res_of(REQ_PRESS,  1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h800000), 1'b1,
              res_of(REQ_TEMP,   1'b0, 1'b0, '0, '0, 1'b0, 1'b0)},
            // negative full scale at 10 bar
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'hFF8000), 1'b1,
              res_of(REQ_NONE, 1'b0, 1'b1, PRESS_W'(-1000000), 16'h8000, 1'b0, 1'b0)},
            '{ev_of(ACT_TICK,       1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_BUS_DONE,   1'b1, 24'h000000), 1'b1,
              res_of(REQ_NONE,   1'b0, 1'b0, '0, '0, 1'b1, 1'b0)},
            '{ev_of(ACT_TICK,       1'b0, 24'h000000), 1'b1,
              res_of(REQ_CMD,    1'b0, 1'b0, '0, '0, 1'b1, 1'b0)},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_DELAY_DONE, 1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'hFFFFFF), 1'b0, '0},
            '{ev_of(ACT_DELAY_DONE, 1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h000000), 1'b0, '0},
            // bus error on the pressure read
            '{ev_of(ACT_BUS_DONE,   1'b1, 24'h7FFFFF), 1'b1,
              res_of(REQ_NONE,   1'b0, 1'b0, '0, '0, 1'b1, 1'b0)},
            '{ev_of(ACT_TICK,       1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_DELAY_DONE, 1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h000000), 1'b0, '0},
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h7FFFFF), 1'b0, '0},
            // positive full scale; success clears the warning
            '{ev_of(ACT_BUS_DONE,   1'b0, 24'h007FFF), 1'b1,
              res_of(REQ_NONE, 1'b0, 1'b1, PRESS_W'(999999), 16'h7FFF, 1'b0, 1'b0)}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            pace();
            send(script[i].ev, script[i].known, script[i].want);
        end

        foreach (seg_range[s])
        begin
            write_range(seg_range[s]);
            repeat (SEGMENT_EVENTS)
            begin
                pace();
                send(pick_event(5, 1'b0), 1'b0, '0);
            end
        end

        // force errors until the sequencer latches, then check it stays dead
        while (!st.fail)
        begin
            pace();
            send(pick_event(50, 1'b1), 1'b0, '0);
        end
        repeat (30)
        begin
            pace();
            send(pick_event(50, 1'b1), 1'b0, '0);
        end

        drain();
        repeat (6) @(posedge clk);
        $display("covered %0d events, %0d results, %0d published measurements",
                 events_sent, results_seen, measurements_published);
        $display("%0d communication failures, %0d range writes, failed latch reached",
                 comm_failures, range_writes);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
